@@ rtl/mtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types and constants for the missing-tooth crank synchronizer.
// ----------------------------------------------------------------------------
package mtc_pkg;

  // field widths
  localparam int TIME_W  = 16;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 8;
  localparam int TOTAL_W = 16;

  // register reset value
  localparam logic [CNT_W-1:0] EDGES_PER_CYCLE_RST = 8'd70;

  // bit of the capture value that tells whether the overflow came before it
  localparam int OVF_TEST_BIT = 15;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // classified edge as passed from front to back
  typedef struct packed {
    logic [STAMP_W-1:0] period;
    logic               rising;
    logic               started;
  } mtc_evt_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } mtc_q_stat_t;

endpackage

@@ rtl/missing_tooth_crank_sync_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// missing_tooth_crank_sync_top
// Missing-tooth crank wheel decoder: timestamps each edge, measures periods
// and tooth times, and tracks sync position against the missing-tooth gap.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  edge_time, overflow_pending, extension_count,
//                                pin_level
//  out      out_valid/out_stall  sync_position, gap_found, lost_sync,
//                                edge_period, tooth_time, teeth_seen
//  cfg      cfg_valid/cfg_ready  cfg_data (edges_per_cycle)
//
// one edge request per cycle sustained while in_stall is low; each result passes
// through a queue entry and then the result register before it is valid.
// the front period subtract and the back tooth add and window compares are each
// combinational; the two-entry queue absorbs a stall of the output side.
// reset is synchronous; cfg_ready is always high.
// in_stall is the queue full flag; the queue fills only while the result is held.
// ----------------------------------------------------------------------------
module missing_tooth_crank_sync_top
  import mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TIME_W-1:0]  edge_time,
  input  logic               overflow_pending,
  input  logic [TIME_W-1:0]  extension_count,
  input  logic               pin_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CNT_W-1:0]   sync_position,
  output logic               gap_found,
  output logic               lost_sync,
  output logic [STAMP_W-1:0] edge_period,
  output logic [STAMP_W-1:0] tooth_time,
  output logic [TOTAL_W-1:0] teeth_seen
);

  mtc_evt_t    front_evt;
  mtc_evt_t    head_evt;
  mtc_q_stat_t q_stat;
  logic        accept;
  logic        pop;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;
  assign cfg_ready = 1'b1;

  // front: timestamp and period
  mtc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .edge_time        (edge_time),
    .overflow_pending (overflow_pending),
    .extension_count  (extension_count),
    .pin_level        (pin_level),
    .evt              (front_evt)
  );

  // request queue
  mtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_evt),
    .pop       (pop),
    .head      (head_evt),
    .stat      (q_stat)
  );

  // back: sync checks and result register
  mtc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .evt           (head_evt),
    .evt_valid     (q_stat.not_empty),
    .evt_pop       (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sync_position (sync_position),
    .gap_found     (gap_found),
    .lost_sync     (lost_sync),
    .edge_period   (edge_period),
    .tooth_time    (tooth_time),
    .teeth_seen    (teeth_seen)
  );

endmodule

@@ rtl/mtc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_front
// Builds the 32-bit timestamp, measures the period since the last edge and
// tags each request with its edge direction and start-up status.
// ----------------------------------------------------------------------------
module mtc_front
  import mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [TIME_W-1:0]  edge_time,
  input  logic               overflow_pending,
  input  logic [TIME_W-1:0]  extension_count,
  input  logic               pin_level,
  output mtc_evt_t           evt
);

  logic [STAMP_W-1:0] previous_timestamp;
  logic               started;
  logic [TIME_W-1:0]  stamp_high;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] period;

  // high word, bumped when the overflow landed before this capture
  always_comb begin
    if (overflow_pending && !edge_time[OVF_TEST_BIT]) begin
      stamp_high = extension_count + TIME_W'(1);
    end else begin
      stamp_high = extension_count;
    end
    stamp = {stamp_high, edge_time};
  end

  // period with the wrap formula: an equal stamp gives all ones
  always_comb begin
    if (stamp > previous_timestamp) begin
      period = stamp - previous_timestamp;
    end else begin
      period = stamp + ~previous_timestamp;
    end
  end

  assign evt.period  = period;
  assign evt.rising  = pin_level;
  assign evt.started = started;

  // timestamp history and start-up flag
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_timestamp <= '0;
      started            <= 1'b0;
    end else if (accept) begin
      previous_timestamp <= stamp;
      started            <= (period != '0);
    end
  end

endmodule

@@ rtl/mtc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_queue
// Two-entry request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mtc_queue
  import mtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  mtc_evt_t    push_data,
  input  logic        pop,
  output mtc_evt_t    head,
  output mtc_q_stat_t stat
);

  mtc_evt_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign stat.full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat.not_empty = (count != '0);
  assign head           = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !(push && !pop))
    else $error("queue push while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.not_empty)
    else $error("queue pop while empty");

endmodule

@@ rtl/mtc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_back
// Runs the tooth-time and edge-parity sync checks on each queued request and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module mtc_back
  import mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [CNT_W-1:0]   cfg_data,
  input  mtc_evt_t           evt,
  input  logic               evt_valid,
  output logic               evt_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CNT_W-1:0]   sync_position,
  output logic               gap_found,
  output logic               lost_sync,
  output logic [STAMP_W-1:0] edge_period,
  output logic [STAMP_W-1:0] tooth_time,
  output logic [TOTAL_W-1:0] teeth_seen
);

  logic [CNT_W-1:0]   edges_per_cycle;
  logic [STAMP_W-1:0] low_phase_time;
  logic [STAMP_W-1:0] previous_tooth_time;
  logic [STAMP_W-1:0] gap_lo;
  logic [STAMP_W-1:0] gap_hi;
  logic [CNT_W-1:0]   edge_counter;
  logic [TOTAL_W-1:0] edge_total;

  logic [STAMP_W-1:0] tooth;
  logic [STAMP_W-1:0] half;
  logic [STAMP_W-1:0] twice;
  logic [CNT_W-1:0]   counter_next;
  logic [CNT_W-1:0]   counter_inc;
  logic [TOTAL_W-1:0] total_next;
  logic               gap_next;
  logic               clear_next;
  logic               gap_window;
  logic               tooth_window;

  // result register frees up when empty or being taken
  assign evt_pop = evt_valid && (!out_valid || !out_stall);

  assign tooth        = evt.period + low_phase_time;
  assign half         = previous_tooth_time >> 1;
  assign twice        = previous_tooth_time << 1;
  assign gap_window   = (tooth > gap_lo) && (tooth < gap_hi);
  assign tooth_window = (tooth > half) && (tooth < twice);
  assign counter_inc  = edge_counter + CNT_W'(1);
  assign total_next   = edge_total + TOTAL_W'(1);

  // sync counter update
  always_comb begin
    counter_next = edge_counter;
    gap_next     = 1'b0;
    clear_next   = 1'b0;
    if (evt.started) begin
      if (evt.rising) begin
        priority if (edge_counter == '0 || edge_counter == edges_per_cycle) begin
          if (gap_window) begin
            counter_next = CNT_W'(1);
            gap_next     = 1'b1;
          end else begin
            counter_next = '0;
            clear_next   = 1'b1;
          end
        end else if (edge_counter == CNT_W'(2) ||
                     (!edge_counter[0] && tooth_window)) begin
          counter_next = counter_inc;
        end else begin
          counter_next = '0;
          clear_next   = 1'b1;
        end
      end else begin
        if (edge_counter[0]) begin
          counter_next = counter_inc;
        end else begin
          counter_next = '0;
          clear_next   = 1'b1;
        end
      end
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      edges_per_cycle <= EDGES_PER_CYCLE_RST;
    end else if (cfg_valid) begin
      edges_per_cycle <= cfg_data;
    end
  end

  // decoder state, gap limits kept ready for the next rising edge
  always_ff @(posedge clk) begin
    if (rst) begin
      low_phase_time      <= '0;
      previous_tooth_time <= '0;
      gap_lo              <= '0;
      gap_hi              <= '0;
      edge_counter        <= '0;
      edge_total          <= '0;
    end else if (evt_pop) begin
      edge_counter <= counter_next;
      edge_total   <= total_next;
      if (evt.started) begin
        if (evt.rising) begin
          previous_tooth_time <= tooth;
          gap_lo              <= tooth + (tooth >> 1);
          gap_hi              <= (tooth << 1) + (tooth >> 1);
        end else begin
          low_phase_time <= evt.period;
        end
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (evt_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (evt_pop) begin
      sync_position <= counter_next;
      gap_found     <= gap_next;
      lost_sync     <= clear_next && (edge_counter != '0);
      edge_period   <= evt.period;
      tooth_time    <= (evt.started && evt.rising) ? tooth : previous_tooth_time;
      teeth_seen    <= total_next;
    end
  end

  a_gap_sets_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && gap_found |-> sync_position == CNT_W'(1))
    else $error("gap result without counter at one");

  a_lost_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && lost_sync |-> sync_position == '0 && !gap_found)
    else $error("lost sync result with nonzero counter");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(teeth_seen))
    else $error("stalled result changed");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    evt_pop |=> teeth_seen == edge_total)
    else $error("edge total out of step with result");

endmodule
